// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the classifier RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on clk_i, disabled while rst_ni is low.
`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on clk_i at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hdl/sqlskc_pkg.sv =====
// ----------------------------------------------------------------------------
// sqlskc_pkg
// Types, constants and character helpers of the statement kind classifier.
// ----------------------------------------------------------------------------
package sqlskc_pkg;

  localparam int unsigned MaxWord  = 6;
  localparam int unsigned LenW     = 3;
  localparam int unsigned BufW     = 8 * MaxWord;

  typedef enum logic [2:0] {
    PH_SKIP  = 3'd0,
    PH_DASH  = 3'd1,
    PH_SLASH = 3'd2,
    PH_LINE  = 3'd3,
    PH_BLOCK = 3'd4,
    PH_WORD  = 3'd5,
    PH_DONE  = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    CLS_SELECT = 3'd0,
    CLS_INSERT = 3'd1,
    CLS_UPDATE = 3'd2,
    CLS_DELETE = 3'd3,
    CLS_WITH   = 3'd4,
    CLS_OTHER  = 3'd5
  } class_e;

  typedef struct packed {
    phase_e          phase;
    logic [LenW-1:0] len;
  } status_t;

  localparam logic [7:0] ChDash    = 8'h2D;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChUnder   = 8'h5F;

  localparam logic [BufW-1:0] KwSelect = 48'h73656C656374;
  localparam logic [BufW-1:0] KwInsert = 48'h696E73657274;
  localparam logic [BufW-1:0] KwUpdate = 48'h757064617465;
  localparam logic [BufW-1:0] KwDelete = 48'h64656C657465;
  localparam logic [BufW-1:0] KwWith   = 48'h000077697468;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           is_upper(c) || (c == ChUnder);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return is_upper(c) ? (c | 8'h20) : c;
  endfunction

  function automatic class_e match_kw(input logic [BufW-1:0] kw,
                                      input logic [LenW-1:0] len);
    class_e cls;
    cls = CLS_OTHER;
    if (len == LenW'(MaxWord)) begin
      if (kw == KwSelect) cls = CLS_SELECT;
      else if (kw == KwInsert) cls = CLS_INSERT;
      else if (kw == KwUpdate) cls = CLS_UPDATE;
      else if (kw == KwDelete) cls = CLS_DELETE;
    end else if ((len == LenW'(4)) && (kw == KwWith)) begin
      cls = CLS_WITH;
    end
    return cls;
  endfunction

endpackage

// ===== hdl/sql_statement_kind_classifier.sv =====
// ----------------------------------------------------------------------------
// sql_statement_kind_classifier
// Classifies a SQL statement by its leading keyword, one text byte per cycle when not stalled.
// ----------------------------------------------------------------------------
// The block takes one byte per clock while it is not stalled: each
// transaction lands in an input register and then steps the scan state
// machine, and the byte flagged final writes its class (0 select, 1 insert,
// 2 update, 3 delete, 4 with, 5 other) into the result register and sets
// its valid flag. Input stalls only while a final byte waits for a result
// register that is still held by the consumer.
// After the final byte the scanner is back at its start state for the next
// statement.
module sql_statement_kind_classifier (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] text_byte_i,
  input  logic       final_byte_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic [2:0] statement_class_o,
  output logic       out_valid_o,
  input  logic       out_ready_i
);

  logic                in_valid_q;
  logic [7:0]          byte_q;
  logic                final_q;
  logic                out_valid_q;
  sqlskc_pkg::class_e  class_q;
  sqlskc_pkg::class_e  step_class;
  sqlskc_pkg::status_t scan_status;
  logic                out_free;
  logic                advance;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && (!final_q || out_free);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q  <= text_byte_i;
      final_q <= final_byte_i;
    end
  end

  sqlskc_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (byte_q),
    .final_i  (final_q),
    .class_o  (step_class),
    .status_o (scan_status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && final_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && final_q) begin
      class_q <= step_class;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign statement_class_o = class_q;

`include "assert_macros.svh"

  `ASSERT_CHK(a_final_restarts, (advance && final_q) |=> (scan_status.phase == sqlskc_pkg::PH_SKIP && scan_status.len == '0), "scanner not restarted after final byte")
  `ASSERT_CHK(a_no_spurious_result, !(advance && final_q) |=> !$rose(out_valid_o), "result without final byte")
  `ASSERT_CHK(a_class_range, out_valid_o |-> (statement_class_o <= 3'd5), "class code out of range")
  `ASSERT_CHK(a_len_bound, scan_status.len <= 3'(sqlskc_pkg::MaxWord), "word length overflow")

endmodule

// ===== hdl/sqlskc_scan.sv =====
// ----------------------------------------------------------------------------
// sqlskc_scan
// Scan state machine: skips blanks and comments, gathers the leading word
// and gives the statement class for the byte being stepped.
// ----------------------------------------------------------------------------
module sqlskc_scan (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  input  logic                 final_i,
  output sqlskc_pkg::class_e   class_o,
  output sqlskc_pkg::status_t  status_o
);

  sqlskc_pkg::phase_e                  phase_q, phase_d;
  logic                                star_q, star_d;
  logic [sqlskc_pkg::BufW-1:0]         kw_q, kw_d;
  logic [sqlskc_pkg::LenW-1:0]         len_q, len_d;
  sqlskc_pkg::class_e                  dec_q, dec_d;
  logic                                take_char;

  assign take_char = (phase_q == sqlskc_pkg::PH_SKIP && !sqlskc_pkg::is_space(byte_i) &&
                      byte_i != sqlskc_pkg::ChDash && byte_i != sqlskc_pkg::ChSlash &&
                      sqlskc_pkg::is_word(byte_i)) ||
                     (phase_q == sqlskc_pkg::PH_WORD && sqlskc_pkg::is_word(byte_i));

  // next state
  always_comb begin
    phase_d = phase_q;
    star_d  = star_q;
    kw_d    = kw_q;
    len_d   = len_q;
    dec_d   = dec_q;
    if (take_char) begin
      if (len_q >= sqlskc_pkg::LenW'(sqlskc_pkg::MaxWord)) begin
        phase_d = sqlskc_pkg::PH_DONE;
        dec_d   = sqlskc_pkg::CLS_OTHER;
      end else begin
        kw_d    = {kw_q[sqlskc_pkg::BufW-9:0], sqlskc_pkg::to_lower(byte_i)};
        len_d   = len_q + sqlskc_pkg::LenW'(1);
        phase_d = sqlskc_pkg::PH_WORD;
      end
    end else begin
      unique case (phase_q)
        sqlskc_pkg::PH_SKIP: begin
          priority if (sqlskc_pkg::is_space(byte_i)) begin
            phase_d = sqlskc_pkg::PH_SKIP;
          end else if (byte_i == sqlskc_pkg::ChDash) begin
            phase_d = sqlskc_pkg::PH_DASH;
          end else if (byte_i == sqlskc_pkg::ChSlash) begin
            phase_d = sqlskc_pkg::PH_SLASH;
          end else begin
            phase_d = sqlskc_pkg::PH_DONE;
            dec_d   = sqlskc_pkg::CLS_OTHER;
          end
        end
        sqlskc_pkg::PH_DASH: begin
          if (byte_i == sqlskc_pkg::ChDash) begin
            phase_d = sqlskc_pkg::PH_LINE;
          end else begin
            phase_d = sqlskc_pkg::PH_DONE;
            dec_d   = sqlskc_pkg::CLS_OTHER;
          end
        end
        sqlskc_pkg::PH_SLASH: begin
          if (byte_i == sqlskc_pkg::ChStar) begin
            phase_d = sqlskc_pkg::PH_BLOCK;
            star_d  = 1'b0;
          end else begin
            phase_d = sqlskc_pkg::PH_DONE;
            dec_d   = sqlskc_pkg::CLS_OTHER;
          end
        end
        sqlskc_pkg::PH_LINE: begin
          if (byte_i == sqlskc_pkg::ChNewline) phase_d = sqlskc_pkg::PH_SKIP;
        end
        sqlskc_pkg::PH_BLOCK: begin
          if (byte_i == sqlskc_pkg::ChSlash && star_q) begin
            phase_d = sqlskc_pkg::PH_SKIP;
            star_d  = 1'b0;
          end else begin
            star_d  = (byte_i == sqlskc_pkg::ChStar);
          end
        end
        sqlskc_pkg::PH_WORD: begin
          phase_d = sqlskc_pkg::PH_DONE;
          dec_d   = sqlskc_pkg::match_kw(kw_q, len_q);
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    unique case (phase_d)
      sqlskc_pkg::PH_WORD: class_o = sqlskc_pkg::match_kw(kw_d, len_d);
      sqlskc_pkg::PH_DONE: class_o = dec_d;
      default:             class_o = sqlskc_pkg::CLS_OTHER;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sqlskc_pkg::PH_SKIP;
      star_q  <= 1'b0;
      kw_q    <= '0;
      len_q   <= '0;
      dec_q   <= sqlskc_pkg::CLS_OTHER;
    end else if (step_i) begin
      if (final_i) begin
        phase_q <= sqlskc_pkg::PH_SKIP;
        star_q  <= 1'b0;
        kw_q    <= '0;
        len_q   <= '0;
        dec_q   <= sqlskc_pkg::CLS_OTHER;
      end else begin
        phase_q <= phase_d;
        star_q  <= star_d;
        kw_q    <= kw_d;
        len_q   <= len_d;
        dec_q   <= dec_d;
      end
    end
  end

  assign status_o.phase = phase_q;
  assign status_o.len   = len_q;

endmodule
